### rtl/jse_pkg.sv
`default_nettype none
package jse_pkg;

  localparam logic [1:0] CmdStart = 2'd0;
  localparam logic [1:0] CmdUnit  = 2'd1;
  localparam logic [1:0] CmdEnd   = 2'd2;

  localparam logic [1:0] ErrNone      = 2'd0;
  localparam logic [1:0] ErrHighAlone = 2'd1;
  localparam logic [1:0] ErrLowAlone  = 2'd2;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChU         = 8'h75;
  localparam logic [7:0] ChB         = 8'h62;
  localparam logic [7:0] ChT         = 8'h74;
  localparam logic [7:0] ChN         = 8'h6e;
  localparam logic [7:0] ChF         = 8'h66;
  localparam logic [7:0] ChR         = 8'h72;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    KIND_QUOTE,
    KIND_SHORT,
    KIND_CTRL,
    KIND_ASCII,
    KIND_UTF2,
    KIND_UTF3,
    KIND_UTF4,
    KIND_ERR
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [20:0] value;
  } desc_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h57 + {4'd0, nib};
    end
    return r;
  endfunction

  function automatic logic [2:0] kind_count(input kind_e kind);
    logic [2:0] r;
    unique case (kind)
      KIND_SHORT: r = 3'd2;
      KIND_CTRL:  r = 3'd6;
      KIND_UTF2:  r = 3'd2;
      KIND_UTF3:  r = 3'd3;
      KIND_UTF4:  r = 3'd4;
      default:    r = 3'd1;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/jse_if.sv
`default_nettype none
interface jse_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] utf16_unit;

  modport source (output valid, output cmd, output utf16_unit, input ready);
  modport sink   (input valid, input cmd, input utf16_unit, output ready);
endinterface

interface jse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic [1:0] error_code;

  modport source (output valid, output out_byte, output last_of_run, output error_code,
                  input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input error_code,
                  output ready);
endinterface
`default_nettype wire

### rtl/jse_front.sv
`default_nettype none
module jse_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  jse_in_if.sink             in_i,
  input  wire logic          q_full_i,
  output jse_pkg::desc_t     q_data_o,
  output logic               q_push_o
);

  logic       pending_q, pending_d;
  logic [9:0] held_q, held_d;
  logic       failed_q, failed_d;
  logic       accept;
  logic       is_high, is_low;
  logic       want_push;
  logic [15:0] unit;
  jse_pkg::desc_t desc;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign unit       = in_i.utf16_unit;
  assign is_high    = unit[15:10] == 6'b110110;
  assign is_low     = unit[15:10] == 6'b110111;

  always_comb begin
    pending_d  = pending_q;
    held_d     = held_q;
    failed_d   = failed_q;
    want_push  = 1'b0;
    desc.kind  = jse_pkg::KIND_QUOTE;
    desc.value = '0;
    unique case (in_i.cmd)
      jse_pkg::CmdStart: begin
        pending_d = 1'b0;
        held_d    = '0;
        failed_d  = 1'b0;
        want_push = 1'b1;
      end
      jse_pkg::CmdUnit: begin
        if (!failed_q) begin
          want_push = 1'b1;
          if (pending_q) begin
            pending_d = 1'b0;
            held_d    = '0;
            if (is_low) begin
              desc.kind  = jse_pkg::KIND_UTF4;
              desc.value = 21'h10000 + {1'b0, held_q, unit[9:0]};
            end else begin
              failed_d   = 1'b1;
              desc.kind  = jse_pkg::KIND_ERR;
              desc.value = {19'd0, jse_pkg::ErrHighAlone};
            end
          end else if (is_high) begin
            want_push = 1'b0;
            pending_d = 1'b1;
            held_d    = unit[9:0];
          end else if (is_low) begin
            failed_d   = 1'b1;
            desc.kind  = jse_pkg::KIND_ERR;
            desc.value = {19'd0, jse_pkg::ErrLowAlone};
          end else begin
            desc.value = {5'd0, unit};
            unique case (unit)
              16'h0008: begin desc.kind = jse_pkg::KIND_SHORT; desc.value = {13'd0, jse_pkg::ChB}; end
              16'h0009: begin desc.kind = jse_pkg::KIND_SHORT; desc.value = {13'd0, jse_pkg::ChT}; end
              16'h000a: begin desc.kind = jse_pkg::KIND_SHORT; desc.value = {13'd0, jse_pkg::ChN}; end
              16'h000c: begin desc.kind = jse_pkg::KIND_SHORT; desc.value = {13'd0, jse_pkg::ChF}; end
              16'h000d: begin desc.kind = jse_pkg::KIND_SHORT; desc.value = {13'd0, jse_pkg::ChR}; end
              16'h0022: begin
                desc.kind  = jse_pkg::KIND_SHORT;
                desc.value = {13'd0, jse_pkg::ChQuote};
              end
              16'h005c: begin
                desc.kind  = jse_pkg::KIND_SHORT;
                desc.value = {13'd0, jse_pkg::ChBackslash};
              end
              default: begin
                if (unit < 16'h0020) begin
                  desc.kind = jse_pkg::KIND_CTRL;
                end else if (unit < 16'h0080) begin
                  desc.kind = jse_pkg::KIND_ASCII;
                end else if (unit < 16'h0800) begin
                  desc.kind = jse_pkg::KIND_UTF2;
                end else begin
                  desc.kind = jse_pkg::KIND_UTF3;
                end
              end
            endcase
          end
        end
      end
      jse_pkg::CmdEnd: begin
        if (!failed_q) begin
          want_push = 1'b1;
          if (pending_q) begin
            pending_d  = 1'b0;
            held_d     = '0;
            failed_d   = 1'b1;
            desc.kind  = jse_pkg::KIND_ERR;
            desc.value = {19'd0, jse_pkg::ErrHighAlone};
          end
        end
      end
      default: begin
        want_push = 1'b0;
      end
    endcase
  end

  assign q_push_o = accept && want_push;
  assign q_data_o = desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      held_q    <= '0;
      failed_q  <= 1'b0;
    end else if (accept) begin
      pending_q <= pending_d;
      held_q    <= held_d;
      failed_q  <= failed_d;
    end
  end

endmodule
`default_nettype wire

### rtl/jse_queue.sv
`default_nettype none
module jse_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire jse_pkg::desc_t  data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 nonempty_o,
  output jse_pkg::desc_t       data_o
);

  jse_pkg::desc_t                 mem_q [jse_pkg::QDepth];
  logic [jse_pkg::QPtrW-1:0]      wr_q, rd_q;
  logic [jse_pkg::QCntW-1:0]      cnt_q;
  logic                           do_push, do_pop;

  localparam logic [jse_pkg::QPtrW-1:0] PtrLast = jse_pkg::QPtrW'(jse_pkg::QDepth - 1);
  localparam logic [jse_pkg::QCntW-1:0] CntFull = jse_pkg::QCntW'(jse_pkg::QDepth);

  assign full_o     = cnt_q == CntFull;
  assign nonempty_o = cnt_q != '0;
  assign data_o     = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/jse_back.sv
`default_nettype none
module jse_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_nonempty_i,
  input  wire jse_pkg::desc_t  q_data_i,
  output logic                 q_pop_o,
  jse_out_if.source            out_o
);

  jse_pkg::desc_t cur_q;
  logic           cur_valid_q;
  logic [2:0]     idx_q;
  logic           last;
  logic           take;
  logic [7:0]     byte_val;
  logic [20:0]    v;

  assign v     = cur_q.value;
  assign last  = idx_q == (jse_pkg::kind_count(cur_q.kind) - 3'd1);
  assign take  = out_o.valid && out_o.ready;
  assign q_pop_o = q_nonempty_i && (!cur_valid_q || (take && last));

  always_comb begin
    byte_val = 8'h00;
    unique case (cur_q.kind)
      jse_pkg::KIND_QUOTE: byte_val = jse_pkg::ChQuote;
      jse_pkg::KIND_SHORT: byte_val = (idx_q == 3'd0) ? jse_pkg::ChBackslash : v[7:0];
      jse_pkg::KIND_CTRL: begin
        case (idx_q)
          3'd0:    byte_val = jse_pkg::ChBackslash;
          3'd1:    byte_val = jse_pkg::ChU;
          3'd4:    byte_val = jse_pkg::hex_digit(v[7:4]);
          3'd5:    byte_val = jse_pkg::hex_digit(v[3:0]);
          default: byte_val = jse_pkg::ChZero;
        endcase
      end
      jse_pkg::KIND_ASCII: byte_val = v[7:0];
      jse_pkg::KIND_UTF2:
        byte_val = (idx_q == 3'd0) ? {3'b110, v[10:6]} : {2'b10, v[5:0]};
      jse_pkg::KIND_UTF3: begin
        case (idx_q)
          3'd0:    byte_val = {4'b1110, v[15:12]};
          3'd1:    byte_val = {2'b10, v[11:6]};
          default: byte_val = {2'b10, v[5:0]};
        endcase
      end
      jse_pkg::KIND_UTF4: begin
        case (idx_q)
          3'd0:    byte_val = {5'b11110, v[20:18]};
          3'd1:    byte_val = {2'b10, v[17:12]};
          3'd2:    byte_val = {2'b10, v[11:6]};
          default: byte_val = {2'b10, v[5:0]};
        endcase
      end
      default: byte_val = 8'h00;
    endcase
  end

  assign out_o.valid       = cur_valid_q;
  assign out_o.out_byte    = byte_val;
  assign out_o.last_of_run = last;
  assign out_o.error_code  = (cur_q.kind == jse_pkg::KIND_ERR) ? v[1:0] : jse_pkg::ErrNone;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (q_pop_o) begin
      cur_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (take) begin
      if (last) begin
        cur_valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/json_string_escape_utf8.sv
// JSON string escaper, UTF-16 code units in, UTF-8 JSON string bytes out.
// An input item is accepted whenever the two-entry queue between the
// classifier and the byte emitter has room, so items can arrive back to
// back. The emitter sends one byte per cycle while the output is ready; an
// item produces 0 bytes for a held high surrogate or an ignored item, 1 for
// quotes, ASCII and errors, 2 to 4 for UTF-8 and short escapes, 6 for
// \u00xx, and the output port sets the sustained rate.
// last_of_run marks the final byte of each item; an error is a single
// result with out_byte zero and a nonzero error_code, after which units and
// end are dropped until the next start.
`default_nettype none
module json_string_escape_utf8 (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  jse_in_if.sink    in_i,
  jse_out_if.source out_o
);

  jse_pkg::desc_t push_data, pop_data;
  logic           push, full, pop, nonempty;

  jse_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (full),
    .q_data_o (push_data),
    .q_push_o (push)
  );

  jse_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .data_i     (push_data),
    .full_o     (full),
    .pop_i      (pop),
    .nonempty_o (nonempty),
    .data_o     (pop_data)
  );

  jse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_nonempty_i (nonempty),
    .q_data_i     (pop_data),
    .q_pop_o      (pop),
    .out_o        (out_o)
  );

endmodule
`default_nettype wire

### tb/sv/tb_json_string_escape_utf8.sv
`timescale 1ns / 1ps
module tb_json_string_escape_utf8;

  localparam logic [1:0] CmdIgnored = 2'd3;
  localparam int unsigned LongHold = 200;
  localparam int unsigned CycleLimit = 300000;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic [1:0] error_code;
  } esc_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  jse_in_if  in_if ();
  jse_out_if out_if ();

  json_string_escape_utf8 u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  esc_byte_t   expected_bytes[$];
  esc_byte_t   run_bytes[$];
  logic        hi_held;
  logic [9:0]  hi_bits;
  logic        str_dead;
  string       hex_chars = "0123456789abcdef";
  bit          idle_on;
  bit          hold_long;
  int unsigned items_sent;
  int unsigned fails;
  int unsigned cycles;

  function automatic void emit_byte(input logic [7:0] b, input logic [1:0] err);
    esc_byte_t e;
    e.out_byte    = b;
    e.last_of_run = 1'b0;
    e.error_code  = err;
    run_bytes.push_back(e);
  endfunction

  function automatic void drop_string(input logic [1:0] err);
    hi_held  = 1'b0;
    hi_bits  = '0;
    str_dead = 1'b1;
    emit_byte(8'h00, err);
  endfunction

  function automatic void encode_text(input logic [15:0] code);
    logic [7:0] esc;
    logic       is_short;
    is_short = 1'b1;
    esc      = 8'h00;
    case (code)
      16'h0008: esc = jse_pkg::ChB;
      16'h0009: esc = jse_pkg::ChT;
      16'h000a: esc = jse_pkg::ChN;
      16'h000c: esc = jse_pkg::ChF;
      16'h000d: esc = jse_pkg::ChR;
      16'h0022: esc = jse_pkg::ChQuote;
      16'h005c: esc = jse_pkg::ChBackslash;
      default:  is_short = 1'b0;
    endcase
    if (is_short) begin
      emit_byte(jse_pkg::ChBackslash, jse_pkg::ErrNone);
      emit_byte(esc, jse_pkg::ErrNone);
    end else if (code < 16'h0020) begin
      emit_byte(jse_pkg::ChBackslash, jse_pkg::ErrNone);
      emit_byte(jse_pkg::ChU, jse_pkg::ErrNone);
      emit_byte(jse_pkg::ChZero, jse_pkg::ErrNone);
      emit_byte(jse_pkg::ChZero, jse_pkg::ErrNone);
      emit_byte(8'(hex_chars[code[7:4]]), jse_pkg::ErrNone);
      emit_byte(8'(hex_chars[code[3:0]]), jse_pkg::ErrNone);
    end else if (code < 16'h0080) begin
      emit_byte(code[7:0], jse_pkg::ErrNone);
    end else if (code < 16'h0800) begin
      emit_byte({3'b110, code[10:6]}, jse_pkg::ErrNone);
      emit_byte({2'b10, code[5:0]}, jse_pkg::ErrNone);
    end else begin
      emit_byte({4'b1110, code[15:12]}, jse_pkg::ErrNone);
      emit_byte({2'b10, code[11:6]}, jse_pkg::ErrNone);
      emit_byte({2'b10, code[5:0]}, jse_pkg::ErrNone);
    end
  endfunction

  function automatic void predict_escape(input logic [1:0] cmd, input logic [15:0] code);
    logic [20:0] cp;
    logic        is_high;
    logic        is_low;
    is_high = (code[15:10] == 6'b110110);
    is_low  = (code[15:10] == 6'b110111);
    run_bytes.delete();
    case (cmd)
      jse_pkg::CmdStart: begin
        hi_held  = 1'b0;
        hi_bits  = '0;
        str_dead = 1'b0;
        emit_byte(jse_pkg::ChQuote, jse_pkg::ErrNone);
      end
      jse_pkg::CmdUnit: begin
        if (!str_dead) begin
          if (hi_held) begin
            if (!is_low) begin
              drop_string(jse_pkg::ErrHighAlone);
            end else begin
              cp = 21'h10000 + {1'b0, hi_bits, code[9:0]};
              hi_held = 1'b0;
              hi_bits = '0;
              emit_byte({5'b11110, cp[20:18]}, jse_pkg::ErrNone);
              emit_byte({2'b10, cp[17:12]}, jse_pkg::ErrNone);
              emit_byte({2'b10, cp[11:6]}, jse_pkg::ErrNone);
              emit_byte({2'b10, cp[5:0]}, jse_pkg::ErrNone);
            end
          end else if (is_high) begin
            hi_held = 1'b1;
            hi_bits = code[9:0];
          end else if (is_low) begin
            drop_string(jse_pkg::ErrLowAlone);
          end else begin
            encode_text(code);
          end
        end
      end
      jse_pkg::CmdEnd: begin
        if (!str_dead) begin
          if (hi_held) drop_string(jse_pkg::ErrHighAlone);
          else emit_byte(jse_pkg::ChQuote, jse_pkg::ErrNone);
        end
      end
      default: ;
    endcase
    if (run_bytes.size() > 0) run_bytes[run_bytes.size() - 1].last_of_run = 1'b1;
    foreach (run_bytes[i]) expected_bytes.push_back(run_bytes[i]);
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [15:0] code);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    predict_escape(cmd, code);
    in_if.valid      <= 1'b1;
    in_if.cmd        <= cmd;
    in_if.utf16_unit <= code;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (cmd != CmdIgnored) items_sent++;
  endtask

  function automatic logic [15:0] text_unit();
    logic [15:0] code;
    case ($urandom_range(0, 9))
      0: code = 16'($urandom_range(0, 31));
      1: begin
        case ($urandom_range(0, 6))
          0: code = 16'h0008;
          1: code = 16'h0009;
          2: code = 16'h000a;
          3: code = 16'h000c;
          4: code = 16'h000d;
          5: code = 16'h0022;
          default: code = 16'h005c;
        endcase
      end
      5: code = 16'($urandom_range(16'h0080, 16'h07ff));
      6: code = 16'($urandom_range(16'h0800, 16'hd7ff));
      7: code = 16'($urandom_range(16'he000, 16'hffff));
      default: code = 16'($urandom_range(16'h0020, 16'h007f));
    endcase
    return code;
  endfunction

  task automatic test_no_start();
    send_item(jse_pkg::CmdUnit, 16'h0041);
    send_item(CmdIgnored, 16'hffff);
    send_item(jse_pkg::CmdEnd, 16'h0000);
  endtask

  task automatic test_escapes();
    send_item(jse_pkg::CmdStart, 16'hffff);
    send_item(jse_pkg::CmdUnit, 16'h0008);
    send_item(jse_pkg::CmdUnit, 16'h0009);
    send_item(jse_pkg::CmdUnit, 16'h000a);
    send_item(jse_pkg::CmdUnit, 16'h000c);
    send_item(jse_pkg::CmdUnit, 16'h000d);
    send_item(jse_pkg::CmdUnit, 16'h0022);
    send_item(jse_pkg::CmdUnit, 16'h005c);
    send_item(jse_pkg::CmdUnit, 16'h0000);
    send_item(jse_pkg::CmdUnit, 16'h001f);
    send_item(jse_pkg::CmdUnit, 16'h007f);
    send_item(jse_pkg::CmdUnit, 16'h0080);
    send_item(jse_pkg::CmdUnit, 16'h07ff);
    send_item(jse_pkg::CmdUnit, 16'h0800);
    send_item(jse_pkg::CmdUnit, 16'hffff);
  endtask

  task automatic test_surrogates();
    send_item(jse_pkg::CmdUnit, 16'hd800);
    send_item(jse_pkg::CmdUnit, 16'hdc00);
    send_item(jse_pkg::CmdUnit, 16'hdbff);
    send_item(jse_pkg::CmdUnit, 16'hdfff);
    send_item(jse_pkg::CmdEnd, 16'h0000);
    send_item(jse_pkg::CmdStart, 16'h0000);
    send_item(jse_pkg::CmdUnit, 16'hd83d);
    send_item(jse_pkg::CmdUnit, 16'h0078);
    send_item(jse_pkg::CmdUnit, 16'h0079);
    send_item(jse_pkg::CmdEnd, 16'h0000);
    send_item(jse_pkg::CmdStart, 16'h0000);
    send_item(jse_pkg::CmdUnit, 16'hd800);
    send_item(jse_pkg::CmdEnd, 16'h0000);
    send_item(jse_pkg::CmdStart, 16'h0000);
    send_item(jse_pkg::CmdUnit, 16'hdc00);
    send_item(jse_pkg::CmdStart, 16'h0000);
    send_item(jse_pkg::CmdUnit, 16'hdbff);
    send_item(jse_pkg::CmdStart, 16'h0000);
    send_item(jse_pkg::CmdEnd, 16'h0000);
  endtask

  task automatic test_backpressure();
    hold_long = 1'b1;
    send_item(jse_pkg::CmdStart, 16'h0000);
    repeat (12) send_item(jse_pkg::CmdUnit, 16'($urandom_range(0, 7)));
    send_item(jse_pkg::CmdEnd, 16'h0000);
  endtask

  task automatic test_random_strings(input int unsigned target);
    int unsigned len;
    bit          broken;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(2'($urandom_range(0, 3)), 16'($urandom));
      end else begin
        broken = ($urandom_range(0, 5) == 0);
        len = $urandom_range(0, 12);
        if (!broken || $urandom_range(0, 3) != 0) send_item(jse_pkg::CmdStart, 16'($urandom));
        repeat (len) begin
          if (broken && $urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
              0: send_item(jse_pkg::CmdUnit, 16'hd800 | 16'($urandom_range(0, 1023)));
              1: send_item(jse_pkg::CmdUnit, 16'hdc00 | 16'($urandom_range(0, 1023)));
              2: send_item(jse_pkg::CmdUnit, 16'($urandom));
              default: send_item(CmdIgnored, 16'($urandom));
            endcase
          end else if ($urandom_range(0, 9) == 0) begin
            send_item(jse_pkg::CmdUnit, 16'hd800 | 16'($urandom_range(0, 1023)));
            send_item(jse_pkg::CmdUnit, 16'hdc00 | 16'($urandom_range(0, 1023)));
          end else begin
            send_item(jse_pkg::CmdUnit, text_unit());
          end
        end
        if (!broken || $urandom_range(0, 3) != 0) send_item(jse_pkg::CmdEnd, 16'($urandom));
      end
    end
  endtask

  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_if.ready <= 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
        hold_long = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    esc_byte_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected item: out_byte %h last_of_run %0d error_code %0d",
               out_if.out_byte, out_if.last_of_run, out_if.error_code);
        fails++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_if.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_if.out_byte);
          fails++;
        end
        if (out_if.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", want.last_of_run, out_if.last_of_run);
          fails++;
        end
        if (out_if.error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, out_if.error_code);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** json_string_escape_utf8: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.cmd        = jse_pkg::CmdStart;
    in_if.utf16_unit = 16'h0000;
    hi_held          = 1'b0;
    hi_bits          = '0;
    str_dead         = 1'b0;
    idle_on          = 1'b1;
    hold_long        = 1'b0;
    items_sent       = 0;
    fails            = 0;
    cycles           = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_no_start();
    test_escapes();
    test_surrogates();
    test_backpressure();
    test_random_strings(items_sent + 230);
    idle_on = 1'b0;
    test_random_strings(items_sent + 60);
    in_if.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fails == 0 && expected_bytes.size() == 0) begin
      $display("** json_string_escape_utf8: PASSED **");
    end else begin
      $display("** json_string_escape_utf8: FAILED **");
    end
    $finish;
  end

endmodule
